/* src/sorted_set_insert_delete_member_top_assert.svh */
// assertion macros shared by the sorted set rtl
// no dependencies; included by the modules that carry assertions
`ifndef SORTED_SET_INSERT_DELETE_MEMBER_TOP_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_MEMBER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSIDM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SSIDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ssidm_pkg.sv */
// shared types and codes for the sorted set block
// no dependencies; used by ssidm_cell and sorted_set_insert_delete_member_top
package ssidm_pkg;

  localparam int KEY_W = 32;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // what a transaction is doing as it walks down the chain
  typedef enum logic [3:0] {
    MODE_SEARCH = 4'b0001,
    MODE_INSERT = 4'b0010,
    MODE_DELETE = 4'b0100,
    MODE_DONE   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic             vld;
    mode_t            mode;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;        // search key, or the carried key while inserting
    logic             full;       // store was full when the transaction started
    logic             success;
    logic             store_full;
  } tok_t;

endpackage

/* src/ssidm_cell.sv */
// one cell of the sorted key chain: holds one key and processes the passing token
// depends on ssidm_pkg
module ssidm_cell #(
  parameter int REM_W = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ssidm_pkg::tok_t             tok_in,
  input  logic [REM_W-1:0]            rem_in,
  input  logic [ssidm_pkg::KEY_W-1:0] right_key,
  output ssidm_pkg::tok_t             tok_out,
  output logic [REM_W-1:0]            rem_out,
  output logic [ssidm_pkg::KEY_W-1:0] key_out
);

  logic [ssidm_pkg::KEY_W-1:0] key;
  logic [ssidm_pkg::KEY_W-1:0] key_next;
  ssidm_pkg::tok_t             tok_next;
  logic [REM_W-1:0]            rem_next;
  logic                        occ;
  logic                        eq;
  logic [REM_W-1:0]            rem_dec;

  // rem counts occupied cells from this one onward
  assign occ     = (rem_in != '0);
  assign rem_dec = occ ? (rem_in - REM_W'(1)) : rem_in;
  assign eq      = occ && (key == tok_in.key);

  always_comb begin
    tok_next = tok_in;
    rem_next = rem_dec;
    key_next = key;
    if (tok_in.vld) begin
      case (tok_in.mode)
        ssidm_pkg::MODE_SEARCH: begin
          if (!(occ && ($signed(key) < $signed(tok_in.key)))) begin
            tok_next.mode = ssidm_pkg::MODE_DONE;
            case (tok_in.cmd)
              ssidm_pkg::CMD_QUERY: begin
                tok_next.success = eq;
              end
              ssidm_pkg::CMD_INSERT: begin
                if (eq) begin
                  tok_next.success = 1'b0;
                end else if (tok_in.full) begin
                  tok_next.store_full = 1'b1;
                end else begin
                  key_next         = tok_in.key;
                  tok_next.success = 1'b1;
                  if (occ) begin
                    // push the old key to the right
                    tok_next.mode = ssidm_pkg::MODE_INSERT;
                    tok_next.key  = key;
                  end
                end
              end
              ssidm_pkg::CMD_DELETE: begin
                if (eq) begin
                  tok_next.success = 1'b1;
                  key_next         = right_key;
                  if (rem_in != REM_W'(1)) begin
                    tok_next.mode = ssidm_pkg::MODE_DELETE;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ssidm_pkg::MODE_INSERT: begin
          key_next = tok_in.key;
          if (occ) begin
            tok_next.key = key;
          end else begin
            tok_next.mode = ssidm_pkg::MODE_DONE;
          end
        end
        ssidm_pkg::MODE_DELETE: begin
          // close the gap from the right neighbor
          key_next = right_key;
          if (rem_in == REM_W'(1)) begin
            tok_next.mode = ssidm_pkg::MODE_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
    rem_out <= rem_next;
  end

  assign key_out = key;

endmodule

/* src/sorted_set_insert_delete_member_top.sv */
// sorted set of distinct signed keys built as a chain of CAPACITY key cells
// a command passes from the entry register through every cell register in turn, then into the output register
// only one command is in the chain at a time, since its token walks every cell once
// the next command is taken as soon as a result reaches the output register
// reset (rst, synchronous) clears the entry count and all valids; keys are not cleared
module sorted_set_insert_delete_member_top #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ssidm_pkg::CMD_W-1:0]        cmd,
  input  logic signed [ssidm_pkg::KEY_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               success,
  output logic                               store_full
);

  `include "sorted_set_insert_delete_member_top_assert.svh"

  localparam int CW = $clog2(CAPACITY + 1);

  ssidm_pkg::tok_t             tok_chain [CAPACITY+1];
  logic [CW-1:0]               rem_chain [CAPACITY+1];
  logic [ssidm_pkg::KEY_W-1:0] keys      [CAPACITY];

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            busy;
  logic            res_valid;
  logic            res_success;
  logic            res_full;
  logic            pend_valid;
  logic            pend_success;
  logic            pend_full;
  ssidm_pkg::tok_t tail;
  logic            tail_success;
  logic            tail_full;
  logic            res_free;
  logic            in_fire;
  logic            at_capacity;
  logic            tail_insert_ok;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign tail     = tok_chain[CAPACITY];
  assign res_free = !res_valid || out_ready;

  assign at_capacity    = (count == CW'(CAPACITY));
  assign tail_insert_ok = tail.vld && tail.success && (tail.cmd == ssidm_pkg::CMD_INSERT);

  // a search that ran off the end means every cell held a smaller key
  assign tail_success = tail.success;
  assign tail_full    = tail.store_full ||
                        ((tail.mode == ssidm_pkg::MODE_SEARCH) &&
                         (tail.cmd == ssidm_pkg::CMD_INSERT));

  always_comb begin
    count_next = count;
    if (tail.success && (tail.cmd == ssidm_pkg::CMD_INSERT)) begin
      count_next = count + CW'(1);
    end else if (tail.success && (tail.cmd == ssidm_pkg::CMD_DELETE)) begin
      count_next = count - CW'(1);
    end
  end

  // entry register feeding the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_chain[0].vld <= 1'b0;
    end else if (in_fire) begin
      tok_chain[0].vld        <= 1'b1;
      tok_chain[0].mode       <= ssidm_pkg::MODE_SEARCH;
      tok_chain[0].cmd        <= cmd;
      tok_chain[0].key        <= value;
      tok_chain[0].full       <= at_capacity;
      tok_chain[0].success    <= 1'b0;
      tok_chain[0].store_full <= 1'b0;
    end else begin
      tok_chain[0].vld <= 1'b0;
    end
    if (in_fire) begin
      rem_chain[0] <= count;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ssidm_pkg::KEY_W-1:0] right_key;
    if (i == CAPACITY - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_mid
      assign right_key = keys[i+1];
    end
    ssidm_cell #(
      .REM_W(CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok_chain[i]),
      .rem_in   (rem_chain[i]),
      .right_key(right_key),
      .tok_out  (tok_chain[i+1]),
      .rem_out  (rem_chain[i+1]),
      .key_out  (keys[i])
    );
  end

  // output register with a one-deep park for a result that arrives while it is full
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
      count      <= '0;
    end else begin
      if (in_fire) begin
        busy <= 1'b1;
      end
      if (res_valid && out_ready) begin
        res_valid <= 1'b0;
      end
      if (tail.vld) begin
        count <= count_next;
        if (res_free) begin
          res_valid   <= 1'b1;
          res_success <= tail_success;
          res_full    <= tail_full;
          busy        <= 1'b0;
        end else begin
          pend_valid   <= 1'b1;
          pend_success <= tail_success;
          pend_full    <= tail_full;
        end
      end else if (pend_valid && res_free) begin
        res_valid   <= 1'b1;
        res_success <= pend_success;
        res_full    <= pend_full;
        pend_valid  <= 1'b0;
        busy        <= 1'b0;
      end
    end
  end

  assign out_valid  = res_valid;
  assign success    = res_success;
  assign store_full = res_full;

  `SSIDM_ASSERT_SAME(a_count_range, clk, rst, 1'b1, count <= CW'(CAPACITY), "count above capacity")
  `SSIDM_ASSERT_NEXT(a_accept_busy, clk, rst, in_fire, busy && tok_chain[0].vld, "not in flight")
  `SSIDM_ASSERT_SAME(a_tail_busy, clk, rst, tail.vld, busy && !pend_valid, "stray token")
  `SSIDM_ASSERT_SAME(a_pend_res, clk, rst, pend_valid, res_valid && busy, "stray park")
  `SSIDM_ASSERT_SAME(a_insert_room, clk, rst, tail_insert_ok, !at_capacity, "insert when full")

endmodule

/* tb/tb_sorted_set_insert_delete_member_top.sv */
// testbench for the sorted set block: random query, insert and delete transactions
// checked against an in-bench sorted array predictor; depends on ssidm_pkg and the rtl top
`timescale 1ns / 100ps

module tb_sorted_set_insert_delete_member_top;

  localparam int CAPACITY = 64;
  localparam int CLK_PERIOD = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int LONG_HOLD = 500;
  localparam int KEY_POOL_SIZE = 128;
  localparam logic [ssidm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [ssidm_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [ssidm_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [ssidm_pkg::CMD_W-1:0]        op;
    logic signed [ssidm_pkg::KEY_W-1:0] key;
  } set_cmd_t;

  typedef struct packed {
    logic ok;
    logic full;
  } outcome_t;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [ssidm_pkg::CMD_W-1:0]        cmd = '0;
  logic signed [ssidm_pkg::KEY_W-1:0] value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic                               success;
  logic                               store_full;

  // predictor state
  logic signed [ssidm_pkg::KEY_W-1:0] set_keys [CAPACITY];
  int                                 set_count = 0;

  set_cmd_t                           cmd_backlog [$];
  outcome_t                           expected_outcomes [$];
  logic signed [ssidm_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];

  bit       in_took = 1'b0;
  bit       out_took = 1'b0;
  int       mismatches = 0;
  int       results_seen = 0;
  int       cmds_sent = 0;
  int       send_wait = 0;
  int       recv_wait = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  set_cmd_t next_cmd;
  outcome_t predicted;
  outcome_t oldest;

  sorted_set_insert_delete_member_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .success   (success),
    .store_full(store_full)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // sorted array kept packed from index 0, same order the block keeps
  function automatic void update_sorted_set(input logic [ssidm_pkg::CMD_W-1:0] op,
                                            input logic signed [ssidm_pkg::KEY_W-1:0] key,
                                            output outcome_t res);
    int pos;
    int i;
    bit hit;
    pos = 0;
    while (pos < set_count && set_keys[pos] < key) pos++;
    hit = (pos < set_count) && (set_keys[pos] == key);
    res = '0;
    case (op)
      ssidm_pkg::CMD_QUERY: begin
        res.ok = hit;
      end
      ssidm_pkg::CMD_INSERT: begin
        if (!hit) begin
          if (set_count >= CAPACITY) begin
            res.full = 1'b1;
          end else begin
            for (i = set_count; i > pos; i--) set_keys[i] = set_keys[i-1];
            set_keys[pos] = key;
            set_count++;
            res.ok = 1'b1;
          end
        end
      end
      ssidm_pkg::CMD_DELETE: begin
        if (hit) begin
          for (i = pos; i < set_count - 1; i++) set_keys[i] = set_keys[i+1];
          set_count--;
          res.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 25;
      default: return 100;
    endcase
  endfunction

  function automatic int draw_wait(input int pct);
    if ($urandom_range(0, 99) < pct) return $urandom_range(0, 19);
    return 0;
  endfunction

  function automatic logic signed [ssidm_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [ssidm_pkg::CMD_W-1:0] pick_op(input int ins_pct,
                                                          input int del_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return ssidm_pkg::CMD_INSERT;
    if (r < ins_pct + del_pct) return ssidm_pkg::CMD_DELETE;
    if (r < 97) return ssidm_pkg::CMD_QUERY;
    return CMD_UNUSED;
  endfunction

  task automatic add_cmd(input logic [ssidm_pkg::CMD_W-1:0] op,
                         input logic signed [ssidm_pkg::KEY_W-1:0] key);
    cmd_backlog.push_back('{op: op, key: key});
  endtask

  task automatic add_random_phase(input int n, input int ins_pct, input int del_pct);
    int k;
    for (k = 0; k < n; k++) add_cmd(pick_op(ins_pct, del_pct), pick_key());
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // driver: one transaction offered at a time, held until taken
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_took)) begin
      if (send_wait > 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (cmd_backlog.size() != 0) begin
        next_cmd = cmd_backlog.pop_front();
        cmd      <= next_cmd.op;
        value    <= next_cmd.key;
        in_valid <= 1'b1;
        if (cmds_sent % 32 == 0) send_idle_pct = pick_idle_pct();
        send_wait = draw_wait(send_idle_pct);
        cmds_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready; two long holds let the block fill and stall its input
  always @(negedge clk) begin
    if (!rst) begin
      if (out_took) begin
        if (results_seen % 32 == 0) recv_idle_pct = pick_idle_pct();
        recv_wait = draw_wait(recv_idle_pct);
        if (results_seen == 40 || results_seen == 400) recv_wait = LONG_HOLD;
      end
      if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: check results, then predict for the transaction taken at this edge
  always @(posedge clk) begin
    in_took  = 1'b0;
    out_took = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        out_took = 1'b1;
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          oldest = expected_outcomes.pop_front();
          if (success !== oldest.ok || store_full !== oldest.full)
            note_mismatch($sformatf(
              "result %0d: success exp %0b got %0b, store_full exp %0b got %0b",
              results_seen, oldest.ok, success, oldest.full, store_full));
        end
      end
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        update_sorted_set(cmd, value, predicted);
        expected_outcomes.push_back(predicted);
      end
    end
  end

  initial begin
    int i;
    int round;
    int n_items;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    // neighbors around zero exercise adjacent compares
    for (i = 4; i < 32; i++) key_pool[i] = i - 18;
    for (i = 32; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    // directed: extremes, each command, duplicates, absent keys, unused code, empty set
    add_cmd(ssidm_pkg::CMD_QUERY, 0);
    add_cmd(ssidm_pkg::CMD_DELETE, 0);
    add_cmd(ssidm_pkg::CMD_INSERT, KEY_MIN);
    add_cmd(ssidm_pkg::CMD_INSERT, KEY_MAX);
    add_cmd(ssidm_pkg::CMD_INSERT, 0);
    add_cmd(ssidm_pkg::CMD_INSERT, -1);
    add_cmd(ssidm_pkg::CMD_QUERY, KEY_MIN);
    add_cmd(ssidm_pkg::CMD_QUERY, KEY_MAX);
    add_cmd(ssidm_pkg::CMD_QUERY, 1);
    add_cmd(ssidm_pkg::CMD_INSERT, KEY_MAX);
    add_cmd(ssidm_pkg::CMD_DELETE, 5);
    add_cmd(CMD_UNUSED, KEY_MAX);
    add_cmd(CMD_UNUSED, 0);
    add_cmd(ssidm_pkg::CMD_INSERT, 32'sh5555_5555);
    add_cmd(ssidm_pkg::CMD_INSERT, 32'shaaaa_aaaa);
    add_cmd(ssidm_pkg::CMD_QUERY, 32'shaaaa_aaaa);
    add_cmd(ssidm_pkg::CMD_DELETE, KEY_MIN);
    add_cmd(ssidm_pkg::CMD_QUERY, KEY_MIN);
    add_cmd(ssidm_pkg::CMD_DELETE, 0);
    add_cmd(ssidm_pkg::CMD_DELETE, -1);
    add_cmd(ssidm_pkg::CMD_DELETE, KEY_MAX);
    add_cmd(ssidm_pkg::CMD_DELETE, 32'sh5555_5555);
    add_cmd(ssidm_pkg::CMD_DELETE, 32'shaaaa_aaaa);
    add_cmd(ssidm_pkg::CMD_QUERY, 32'shaaaa_aaaa);

    // random: fill past capacity, churn while full, then drain
    for (round = 0; round < 3; round++) begin
      add_random_phase(110, 85, 5);
      add_random_phase(40, 35, 35);
      add_random_phase(70, 5, 80);
    end
    n_items = cmd_backlog.size();

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // every transaction sent must come back before the run is judged
    wait (results_seen == n_items);
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

endmodule
